[design/psra_pkg.sv]
`default_nettype none

package psra_pkg;

  localparam int MODE_W    = 1;
  localparam int SAMPLE_W  = 8;
  localparam int OFFSET_W  = 9;
  localparam int RDATA_W   = 8;
  localparam int WSUM_W    = 17;
  localparam int AVG_W     = 16;
  localparam int FILL_W    = 3;

  // Fractional bits of the average.
  localparam int AVG_FRAC  = 8;
  // Largest sample value.
  localparam int SAMPLE_MAX = 255;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [RDATA_W-1:0]  rdata_t;
  typedef logic [WSUM_W-1:0]   wsum_t;
  typedef logic [AVG_W-1:0]    avg_t;
  typedef logic [FILL_W-1:0]   fill_t;

  localparam mode_t MODE_WRITE = 1'b0;
  localparam mode_t MODE_READ  = 1'b1;

  typedef struct packed {
    logic load_mid;
    logic load_out;
  } stage_en_t;

endpackage

`default_nettype wire

[design/psra_if.sv]
`default_nettype none

interface psra_in_if;
  logic              valid;
  logic              ready;
  psra_pkg::mode_t   mode;
  psra_pkg::sample_t sample;
  psra_pkg::offset_t read_offset;

  modport source(output valid, output mode, output sample, output read_offset, input ready);
  modport sink(input valid, input mode, input sample, input read_offset, output ready);
endinterface

interface psra_out_if;
  logic              valid;
  logic              ready;
  psra_pkg::rdata_t  read_data;
  psra_pkg::wsum_t   window_sum;
  psra_pkg::avg_t    average_q8;
  psra_pkg::fill_t   fill_partition;

  modport source(output valid, output read_data, output window_sum, output average_q8,
                 output fill_partition, input ready);
  modport sink(input valid, input read_data, input window_sum, input average_q8,
               input fill_partition, output ready);
endinterface

`default_nettype wire

[design/psra_ram.sv]
`default_nettype none

module psra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/psra_ctrl.sv]
`default_nettype none

module psra_ctrl #(
  parameter int PART_LEN = 64,
  parameter int PARTS    = 8,
  localparam int RING    = PARTS * PART_LEN,
  localparam int WIN     = (PARTS - 1) * PART_LEN,
  localparam int AW      = $clog2(RING),
  localparam int FW      = $clog2(PARTS),
  localparam int WPW     = (PART_LEN > 1) ? $clog2(PART_LEN) : 1,
  localparam int PSW     = $clog2(psra_pkg::SAMPLE_MAX * PART_LEN + 1),
  localparam int WSW     = $clog2(psra_pkg::SAMPLE_MAX * WIN + 1),
  localparam int OFW     = psra_pkg::OFFSET_W,
  localparam int SMW     = ((AW > OFW) ? AW : OFW) + 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire psra_pkg::mode_t   mode_i,
  input  wire psra_pkg::sample_t sample_i,
  input  wire psra_pkg::offset_t offset_i,
  output logic [WSW-1:0]         win_o,
  output logic [FW-1:0]          fill_o,
  output psra_pkg::rdata_t       rdata_o
);

  logic [FW-1:0]    fill_q, fill_next, fill_next2;
  logic [WPW-1:0]   wpos_q;
  logic [PSW-1:0]   part_q, part_new, last_q, old_sum, sum_rdata;
  logic [WSW-1:0]   win_q, win_next;
  logic [WSW:0]     win_wide;
  logic [AW-1:0]    fbase_q, obase_q, obase_next, samp_addr, rd_addr;
  logic [PARTS-1:0] sv_q;
  logic             srd_valid_q;
  logic             wr, rd, wrap;
  logic [OFW-1:0]   off_mod;
  logic [SMW-1:0]   rd_sum;

  assign wr   = accept_i && (mode_i == psra_pkg::MODE_WRITE);
  assign rd   = accept_i && (mode_i == psra_pkg::MODE_READ);
  assign wrap = wr && (wpos_q == WPW'(PART_LEN - 1));

  assign part_new   = part_q + PSW'(sample_i);
  assign fill_next  = (fill_q == FW'(PARTS - 1)) ? '0 : fill_q + FW'(1);
  assign fill_next2 = (fill_next == FW'(PARTS - 1)) ? '0 : fill_next + FW'(1);
  assign obase_next = (obase_q == AW'(RING - PART_LEN)) ? '0 : obase_q + AW'(PART_LEN);

  // With two partitions the next one is always the one completed last.
  assign old_sum  = (PARTS == 2) ? last_q : (srd_valid_q ? sum_rdata : '0);
  assign win_wide = (WSW+1)'(win_q) + (WSW+1)'(part_new) - (WSW+1)'(old_sum);
  assign win_next = win_wide[WSW-1:0];

  // The offset is reduced modulo the ring length before it is added to the base.
  always_comb begin
    off_mod = offset_i;
    for (int k = OFW - 1; k >= 0; k--) begin
      if ((RING << k) < (1 << OFW)) begin
        if (off_mod >= OFW'(RING << k)) begin
          off_mod = off_mod - OFW'(RING << k);
        end
      end
    end
    rd_sum = SMW'(obase_q) + SMW'(off_mod);
    if (rd_sum >= SMW'(RING)) begin
      rd_sum = rd_sum - SMW'(RING);
    end
    rd_addr = rd_sum[AW-1:0];
  end

  assign samp_addr = wr ? (fbase_q + AW'(wpos_q)) : rd_addr;

  psra_ram #(
    .WIDTH(psra_pkg::SAMPLE_W),
    .DEPTH(RING)
  ) u_samples (
    .clk_i  (clk_i),
    .we_i   (wr),
    .waddr_i(samp_addr),
    .wdata_i(sample_i),
    .re_i   (rd),
    .raddr_i(samp_addr),
    .rdata_o(rdata_o)
  );

  psra_ram #(
    .WIDTH(PSW),
    .DEPTH(PARTS)
  ) u_sums (
    .clk_i  (clk_i),
    .we_i   (wrap),
    .waddr_i(fill_q),
    .wdata_i(part_new),
    .re_i   (wrap),
    .raddr_i(fill_next2),
    .rdata_o(sum_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      wpos_q      <= '0;
      part_q      <= '0;
      win_q       <= '0;
      last_q      <= '0;
      fbase_q     <= '0;
      obase_q     <= AW'(PART_LEN);
      sv_q        <= '0;
      srd_valid_q <= 1'b0;
    end else if (wrap) begin
      fill_q           <= fill_next;
      wpos_q           <= '0;
      part_q           <= '0;
      win_q            <= win_next;
      last_q           <= part_new;
      fbase_q          <= obase_q;
      obase_q          <= obase_next;
      sv_q[fill_q]     <= 1'b1;
      srd_valid_q      <= sv_q[fill_next2];
    end else if (wr) begin
      wpos_q <= wpos_q + WPW'(1);
      part_q <= part_new;
    end
  end

  assign win_o  = wrap ? win_next : win_q;
  assign fill_o = wrap ? fill_next : fill_q;

endmodule

`default_nettype wire

[design/psra_avg.sv]
`default_nettype none

module psra_avg #(
  parameter int PART_LEN = 64,
  parameter int PARTS    = 8,
  localparam int WIN     = (PARTS - 1) * PART_LEN,
  localparam int WSW     = $clog2(psra_pkg::SAMPLE_MAX * WIN + 1),
  localparam int NB      = WSW + psra_pkg::AVG_FRAC,
  localparam int SH      = NB + $clog2(WIN),
  localparam int MW      = NB + 1,
  localparam int MLW     = MW / 2,
  localparam int MHW     = MW - MLW,
  localparam int PLW     = WSW + MLW,
  localparam int PHW     = WSW + MHW,
  localparam int PRW     = WSW + MW
) (
  input  wire logic                clk_i,
  input  wire psra_pkg::stage_en_t en_i,
  input  wire logic [WSW-1:0]      win_i,
  output psra_pkg::avg_t           avg_o
);

  // Reciprocal of the window length, exact for every window sum.
  localparam logic [63:0]    MULT = ((64'd1 << SH) + 64'(WIN) - 64'd1) / 64'(WIN);
  localparam logic [MLW-1:0] ML   = MULT[MLW-1:0];
  localparam logic [MHW-1:0] MH   = MULT[MW-1:MLW];

  logic [PLW-1:0] pl_q;
  logic [PHW-1:0] ph_q;
  logic [PRW-1:0] total, quot;
  psra_pkg::avg_t avg_q;

  assign total = (PRW'(ph_q) << MLW) + PRW'(pl_q);
  assign quot  = total >> (SH - psra_pkg::AVG_FRAC);

  always_ff @(posedge clk_i) begin
    if (en_i.load_mid) begin
      pl_q <= PLW'(win_i) * PLW'(ML);
      ph_q <= PHW'(win_i) * PHW'(MH);
    end
    if (en_i.load_out) begin
      avg_q <= quot[psra_pkg::AVG_W-1:0];
    end
  end

  assign avg_o = avg_q;

endmodule

`default_nettype wire

[design/partitioned_sample_ring_average.sv]
`default_nettype none

// Channel  Role    Payload
// in_i     sink    mode, sample, read_offset
// out_o    source  read_data, window_sum, average_q8, fill_partition
//
// One request is taken every cycle unless a stalled result has filled the pipeline. Results
// pass the stage 1, middle and output registers: the registered sample memory read and the
// average multiplier, whose two partial products are summed into the output register.
// Reset clears the fill position, the running sums and the pipeline valid flags.
// A stalled result holds in the output register while the next requests move up
// behind it until the pipeline is full.
module partitioned_sample_ring_average #(
  parameter int PART_LEN = 64,
  parameter int PARTS    = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  psra_in_if.sink     in_i,
  psra_out_if.source  out_o
);

  localparam int WIN = (PARTS - 1) * PART_LEN;
  localparam int WSW = $clog2(psra_pkg::SAMPLE_MAX * WIN + 1);
  localparam int FW  = $clog2(PARTS);

  logic                in_ready, accept;
  psra_pkg::stage_en_t en;
  logic [WSW-1:0]      win_d;
  logic [FW-1:0]       fill_d;
  psra_pkg::rdata_t    ram_rdata;

  logic                v1_q, v2_q, vo_q;
  psra_pkg::mode_t     mode1_q;
  logic [WSW-1:0]      win1_q, win2_q;
  logic [FW-1:0]       fill1_q, fill2_q;
  psra_pkg::rdata_t    rd2_q, rdo_q;
  psra_pkg::wsum_t     wino_q;
  psra_pkg::fill_t     fillo_q;
  psra_pkg::avg_t      avg;

  assign en.load_out = v2_q && (!vo_q || out_o.ready);
  assign en.load_mid = v1_q && (!v2_q || en.load_out);
  assign in_ready    = !v1_q || en.load_mid;
  assign accept      = in_i.valid && in_ready;
  assign in_i.ready  = in_ready;

  psra_ctrl #(
    .PART_LEN(PART_LEN),
    .PARTS   (PARTS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .mode_i  (in_i.mode),
    .sample_i(in_i.sample),
    .offset_i(in_i.read_offset),
    .win_o   (win_d),
    .fill_o  (fill_d),
    .rdata_o (ram_rdata)
  );

  psra_avg #(
    .PART_LEN(PART_LEN),
    .PARTS   (PARTS)
  ) u_avg (
    .clk_i(clk_i),
    .en_i (en),
    .win_i(win1_q),
    .avg_o(avg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (accept) begin
        v1_q <= 1'b1;
      end else if (en.load_mid) begin
        v1_q <= 1'b0;
      end
      if (en.load_mid) begin
        v2_q <= 1'b1;
      end else if (en.load_out) begin
        v2_q <= 1'b0;
      end
      if (en.load_out) begin
        vo_q <= 1'b1;
      end else if (out_o.ready) begin
        vo_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode1_q <= in_i.mode;
      win1_q  <= win_d;
      fill1_q <= fill_d;
    end
    if (en.load_mid) begin
      rd2_q   <= (mode1_q == psra_pkg::MODE_READ) ? ram_rdata : '0;
      win2_q  <= win1_q;
      fill2_q <= fill1_q;
    end
    if (en.load_out) begin
      rdo_q   <= rd2_q;
      wino_q  <= psra_pkg::wsum_t'(win2_q);
      fillo_q <= psra_pkg::fill_t'(fill2_q);
    end
  end

  assign out_o.valid          = vo_q;
  assign out_o.read_data      = rdo_q;
  assign out_o.window_sum     = wino_q;
  assign out_o.average_q8     = avg;
  assign out_o.fill_partition = fillo_q;

endmodule

`default_nettype wire
